// ----- src/gswa_pkg.sv -----
// ----------------------------------------------------------------------------
// gswa_pkg
// Shared types and constants for the weighted-attachment graph store.
// ----------------------------------------------------------------------------
package gswa_pkg;

  // Operation codes carried on in_op.
  localparam logic [2:0] OP_NEW_NODE = 3'd0;
  localparam logic [2:0] OP_ADD_EDGE = 3'd1;
  localparam logic [2:0] OP_DEL_EDGE = 3'd2;
  localparam logic [2:0] OP_QUERY    = 3'd3;
  localparam logic [2:0] OP_CHOOSE   = 3'd4;

  // Fixed field widths.
  localparam int OP_W     = 3;
  localparam int NODE_W   = 7;
  localparam int MOD_W    = 4;
  localparam int RAND_W   = 16;
  localparam int ALPHA_W  = 12;
  localparam int EDGE_W   = 15;

  // Full-scale value of the random fraction.
  localparam logic [15:0] RAND_FULL = 16'hFFFF;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_RD     = 9'b000000100,
    ST_EXEC   = 9'b000001000,
    ST_WR2    = 9'b000010000,
    ST_SUM    = 9'b000100000,
    ST_MULT   = 9'b001000000,
    ST_PICK   = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_t;

endpackage

// ----- src/gswa_ram.sv -----
// ----------------------------------------------------------------------------
// gswa_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gswa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/graph_store_weighted_attachment.sv -----
// ----------------------------------------------------------------------------
// graph_store_weighted_attachment
// Directed graph store with degree-weighted roulette choice of a target.
// ----------------------------------------------------------------------------
// Channel  Ports                                           Handshake
// in       in_op in_from_node in_to_node in_new_module     start / busy
//          in_rand_frac
// out      out_result_node out_ok out_edge_total           done strobe
// cfg      cfg_we cfg_alpha_q                              write enable
//
// After reset a clearing pass runs over the adjacency and node memories,
// one address a cycle, with busy high throughout. New node, add, remove
// and query pass through the read, execute and done states, with a
// second write state when an edge changes; choose makes two scans over the
// per-node memory, one node a cycle. The result strobe cannot be held off.
// ----------------------------------------------------------------------------
module graph_store_weighted_attachment #(
  parameter int MAX_NODES   = 128,
  parameter int MAX_MODULES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [gswa_pkg::OP_W-1:0]     in_op,
  input  logic [gswa_pkg::NODE_W-1:0]   in_from_node,
  input  logic [gswa_pkg::NODE_W-1:0]   in_to_node,
  input  logic [gswa_pkg::MOD_W-1:0]    in_new_module,
  input  logic [gswa_pkg::RAND_W-1:0]   in_rand_frac,
  output logic                          done,
  output logic [gswa_pkg::NODE_W-1:0]   out_result_node,
  output logic                          out_ok,
  output logic [gswa_pkg::EDGE_W-1:0]   out_edge_total,
  input  logic                          cfg_we,
  input  logic [gswa_pkg::ALPHA_W-1:0]  cfg_alpha_q
);

  localparam int IDX_W  = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int MODS_W = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
  localparam int DEG_W  = $clog2(2 * MAX_NODES + 1);
  // Degree times (256 + alpha) plus 256.
  localparam int WGT_W  = DEG_W + 14;
  localparam int SUM_W  = WGT_W + IDX_W + 1;
  localparam int PROD_W = SUM_W + 16;
  localparam int NODE_W = gswa_pkg::NODE_W;

  // Each node's entry: degree, module label.
  localparam int NENT_W = DEG_W + MODS_W;

  gswa_pkg::state_t state_r, state_nxt;

  logic [gswa_pkg::ALPHA_W-1:0] alpha_r;
  logic [CNT_W-1:0]             ncount_r;
  logic [gswa_pkg::EDGE_W-1:0]  ecount_r;

  logic [gswa_pkg::OP_W-1:0]    op_r;
  logic [NODE_W-1:0]            from_r, to_r;
  logic [MODS_W-1:0]            mod_r;
  logic [gswa_pkg::RAND_W-1:0]  rand_r;

  logic [IDX_W-1:0]  idx_r;
  logic [CNT_W-1:0]  scan_r;
  logic              scan_vld_r;
  logic [IDX_W-1:0]  scan_idx_r;
  logic [MAX_NODES-1:0] row_r;
  logic [MODS_W-1:0] src_mod_r;
  logic [SUM_W-1:0]  total_r, run_r;
  logic [PROD_W-1:0] target_r;
  logic              pass2_r;
  logic [DEG_W-1:0]  deg_from_r;

  logic              out_ok_r;
  logic [NODE_W-1:0] out_node_r;
  logic              done_r;

  // Adjacency memory: one row of MAX_NODES bits per source node.
  logic             adj_we;
  logic [IDX_W-1:0] adj_waddr, adj_raddr;
  logic [MAX_NODES-1:0] adj_wdata, adj_rdata;

  gswa_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .raddr(adj_raddr), .rdata(adj_rdata)
  );

  // Node memory: degree and module label per node.
  logic              nd_we;
  logic [IDX_W-1:0]  nd_waddr, nd_raddr;
  logic [NENT_W-1:0] nd_wdata, nd_rdata;

  gswa_ram #(.WIDTH(NENT_W), .DEPTH(MAX_NODES)) u_node (
    .clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
    .raddr(nd_raddr), .rdata(nd_rdata)
  );

  logic [DEG_W-1:0]  rd_deg;
  logic [MODS_W-1:0] rd_mod;
  assign rd_deg = nd_rdata[NENT_W-1:MODS_W];
  assign rd_mod = nd_rdata[MODS_W-1:0];

  // Range checks on the held item; the edge bit comes from the fresh row.
  logic from_ok, to_ok, both_ok, adj_bit;
  assign from_ok = {1'b0, from_r} < (NODE_W + 1)'(ncount_r);
  assign to_ok   = {1'b0, to_r}   < (NODE_W + 1)'(ncount_r);
  assign both_ok = from_ok && to_ok;
  assign adj_bit = adj_rdata[to_r[IDX_W-1:0]];

  // Weight of the node being scanned, from the registered read data.
  logic [WGT_W-1:0] weight;
  logic             cand;
  always_comb begin
    if (rd_mod == src_mod_r) begin
      weight = WGT_W'(rd_deg) * WGT_W'(13'd256 + {1'b0, alpha_r}) + WGT_W'(256);
    end else begin
      weight = WGT_W'({rd_deg, 8'd0}) + WGT_W'(256);
    end
    cand = (scan_idx_r != from_r[IDX_W-1:0]) && !row_r[scan_idx_r];
  end

  logic [SUM_W-1:0]  run_add;
  logic [PROD_W-1:0] run_scaled;
  assign run_add    = run_r + SUM_W'(weight);
  assign run_scaled = PROD_W'(run_add) * PROD_W'(gswa_pkg::RAND_FULL);

  logic add_op;
  assign add_op = (op_r == gswa_pkg::OP_ADD_EDGE);

  // Sequencer and datapath.
  always_comb begin
    state_nxt = state_r;
    adj_we    = 1'b0;
    adj_waddr = from_r[IDX_W-1:0];
    adj_wdata = row_r;
    adj_raddr = from_r[IDX_W-1:0];
    nd_we     = 1'b0;
    nd_waddr  = from_r[IDX_W-1:0];
    nd_wdata  = '0;
    nd_raddr  = from_r[IDX_W-1:0];
    case (state_r)
      gswa_pkg::ST_CLEAR: begin
        adj_we    = 1'b1;
        adj_waddr = idx_r;
        adj_wdata = '0;
        nd_we     = 1'b1;
        nd_waddr  = idx_r;
        if (idx_r == IDX_W'(MAX_NODES - 1)) begin
          state_nxt = gswa_pkg::ST_IDLE;
        end
      end
      gswa_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = gswa_pkg::ST_RD;
        end
      end
      gswa_pkg::ST_RD: begin
        // Row of the source and entry of the source are being read.
        nd_raddr  = from_r[IDX_W-1:0];
        state_nxt = gswa_pkg::ST_EXEC;
      end
      gswa_pkg::ST_EXEC: begin
        nd_raddr = to_r[IDX_W-1:0];
        case (op_r)
          gswa_pkg::OP_NEW_NODE: begin
            if (ncount_r < CNT_W'(MAX_NODES)) begin
              nd_we    = 1'b1;
              nd_waddr = ncount_r[IDX_W-1:0];
              nd_wdata = {DEG_W'(0), mod_r};
            end
            state_nxt = gswa_pkg::ST_DONE;
          end
          gswa_pkg::OP_ADD_EDGE, gswa_pkg::OP_DEL_EDGE: begin
            if (both_ok && (adj_bit != add_op)) begin
              adj_we    = 1'b1;
              adj_wdata = adj_rdata;
              adj_wdata[to_r[IDX_W-1:0]] = add_op;
              nd_we    = 1'b1;
              nd_wdata = {add_op ? rd_deg + DEG_W'(1) : rd_deg - DEG_W'(1), rd_mod};
              state_nxt = gswa_pkg::ST_WR2;
            end else begin
              state_nxt = gswa_pkg::ST_DONE;
            end
          end
          gswa_pkg::OP_CHOOSE: begin
            nd_raddr = '0;
            state_nxt = from_ok ? gswa_pkg::ST_SUM : gswa_pkg::ST_DONE;
          end
          default: state_nxt = gswa_pkg::ST_DONE;
        endcase
      end
      gswa_pkg::ST_WR2: begin
        // Target entry is read now; a self loop moves the old degree by two.
        nd_we    = 1'b1;
        nd_waddr = to_r[IDX_W-1:0];
        if (to_r == from_r) begin
          nd_wdata = {add_op ? deg_from_r + DEG_W'(2) : deg_from_r - DEG_W'(2), rd_mod};
        end else begin
          nd_wdata = {add_op ? rd_deg + DEG_W'(1) : rd_deg - DEG_W'(1), rd_mod};
        end
        state_nxt = gswa_pkg::ST_DONE;
      end
      gswa_pkg::ST_SUM, gswa_pkg::ST_PICK: begin
        nd_raddr = scan_r[IDX_W-1:0];
        if (state_r == gswa_pkg::ST_SUM) begin
          if (!scan_vld_r && scan_r >= ncount_r) begin
            state_nxt = gswa_pkg::ST_MULT;
          end
        end else if ((scan_vld_r && cand && run_scaled >= target_r) ||
                     (!scan_vld_r && scan_r >= ncount_r)) begin
          state_nxt = gswa_pkg::ST_DONE;
        end
      end
      gswa_pkg::ST_MULT: begin
        nd_raddr  = '0;
        state_nxt = gswa_pkg::ST_PICK;
      end
      gswa_pkg::ST_DONE: begin
        state_nxt = gswa_pkg::ST_IDLE;
      end
      default: state_nxt = gswa_pkg::ST_IDLE;
    endcase
  end

  // Control and payload registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= gswa_pkg::ST_CLEAR;
      idx_r      <= '0;
      alpha_r    <= '0;
      ncount_r   <= '0;
      ecount_r   <= '0;
      done_r     <= 1'b0;
      out_ok_r   <= 1'b0;
      out_node_r <= '0;
      scan_vld_r <= 1'b0;
      scan_r     <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= 1'b0;
      if (cfg_we) begin
        alpha_r <= cfg_alpha_q;
      end
      case (state_r)
        gswa_pkg::ST_CLEAR: begin
          idx_r <= idx_r + IDX_W'(1);
        end
        gswa_pkg::ST_IDLE: begin
          if (start) begin
            op_r     <= in_op;
            from_r   <= in_from_node;
            to_r     <= in_to_node;
            mod_r    <= MODS_W'(in_new_module % MAX_MODULES);
            rand_r   <= in_rand_frac;
            out_ok_r <= 1'b0;
            out_node_r <= '0;
          end
        end
        gswa_pkg::ST_RD: begin
        end
        gswa_pkg::ST_EXEC: begin
          row_r      <= adj_rdata;
          deg_from_r <= nd_rdata[NENT_W-1:MODS_W];
          src_mod_r  <= nd_rdata[MODS_W-1:0];
          total_r    <= '0;
          run_r      <= '0;
          scan_r     <= '0;
          scan_vld_r <= 1'b0;
          pass2_r    <= 1'b0;
          // row_r is loaded here; the exec decisions use the fresh read.
          case (op_r)
            gswa_pkg::OP_NEW_NODE: begin
              if (ncount_r < CNT_W'(MAX_NODES)) begin
                out_ok_r   <= 1'b1;
                out_node_r <= NODE_W'(ncount_r);
                ncount_r   <= ncount_r + CNT_W'(1);
              end
            end
            gswa_pkg::OP_ADD_EDGE: begin
              if (both_ok && !adj_rdata[to_r[IDX_W-1:0]]) begin
                out_ok_r <= 1'b1;
                ecount_r <= ecount_r + gswa_pkg::EDGE_W'(1);
              end
            end
            gswa_pkg::OP_DEL_EDGE: begin
              if (both_ok && adj_rdata[to_r[IDX_W-1:0]]) begin
                out_ok_r <= 1'b1;
                ecount_r <= ecount_r - gswa_pkg::EDGE_W'(1);
              end
            end
            gswa_pkg::OP_QUERY: begin
              out_ok_r <= both_ok && adj_rdata[to_r[IDX_W-1:0]];
            end
            default: begin
            end
          endcase
        end
        gswa_pkg::ST_SUM, gswa_pkg::ST_PICK: begin
          // Issue one read a cycle; data for scan_idx_r arrives next cycle.
          if (scan_r < ncount_r) begin
            scan_r     <= scan_r + CNT_W'(1);
            scan_idx_r <= scan_r[IDX_W-1:0];
            scan_vld_r <= 1'b1;
          end else begin
            scan_vld_r <= 1'b0;
          end
          if (scan_vld_r && cand) begin
            if (state_r == gswa_pkg::ST_SUM) begin
              total_r <= total_r + SUM_W'(weight);
            end else begin
              run_r <= run_add;
              if (run_scaled >= target_r && !pass2_r) begin
                pass2_r    <= 1'b1;
                out_ok_r   <= 1'b1;
                out_node_r <= NODE_W'(scan_idx_r);
              end
            end
          end
        end
        gswa_pkg::ST_MULT: begin
          target_r   <= PROD_W'(total_r) * PROD_W'(rand_r);
          scan_r     <= '0;
          scan_vld_r <= 1'b0;
        end
        gswa_pkg::ST_DONE: begin
          done_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Busy whenever the sequencer is away from idle.
  always_comb begin
    busy = (state_r != gswa_pkg::ST_IDLE);
  end

  assign done            = done_r;
  assign out_ok          = out_ok_r;
  assign out_result_node = out_ok_r ? out_node_r : '0;
  assign out_edge_total  = ecount_r;

endmodule
